/* rtl/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and field widths for the PUCT child selection unit.
// ----------------------------------------------------------------------------
package pcs_pkg;

	localparam int ACTION_W = 13;
	localparam int PRIOR_W  = 16;
	localparam int VISITS_W = 20;
	localparam int VSUM_W   = 37;
	localparam int POS_W    = 8;
	localparam int SCORE_W  = 32;
	localparam int GAIN_W   = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6144;

	// Width of the shared compare-subtract unit and its working registers.
	localparam int UNIT_W  = 30;
	localparam int SHIFT_W = 52;
	localparam int ROOT_W  = 26;
	localparam int UTERM_W = 30;

	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 56;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QDIV,
		ST_ROOT,
		ST_MUL1,
		ST_MUL2,
		ST_UDIV,
		ST_SCORE
	} state_t;

endpackage

/* rtl/puct_child_select_unit.sv */
// ----------------------------------------------------------------------------
// puct_child_select_unit
// Scores the children of one search-tree node with the PUCT rule and reports
// the best one when the last child of the node has been transferred.
// ----------------------------------------------------------------------------
// The block takes no new child until it is through with the last one: one
// shared 30-bit compare-subtract unit produces one bit per cycle for the value
// division, the square root of the parent visit count and the exploration
// division; then come the multiply states MUL1 and MUL2, the scoring state
// and the input transfer in the idle state, the only one with s_tready high. The
// score is Q + c*prior*sqrt(parent_visits)/(1+child_visits) in signed Q15.16,
// saturated, and the first child with the strictly greatest score wins. The
// result of a node waits in an output register; if it has not been taken when
// the next node ends, the block holds that last child until the register frees.
module puct_child_select_unit #(
	parameter int MAX_CHILDREN = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pcs_pkg::GAIN_W-1:0]      cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// action_index[12:0], prior[28:13], child_visits[48:29],
	// child_value_sum[85:49], parent_visits[105:86], zero fill above
	input  logic [pcs_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// best_action[12:0], best_position[20:13], score[52:21], zero fill above
	output logic [pcs_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int CNT_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CHILDREN - 1);

	pcs_pkg::state_t state_q, state_d;

	logic [pcs_pkg::GAIN_W-1:0]    gain_q;

	logic [pcs_pkg::ACTION_W-1:0]  action_q;
	logic [pcs_pkg::PRIOR_W-1:0]   prior_q;
	logic [pcs_pkg::VISITS_W-1:0]  visits_q;
	logic [pcs_pkg::VISITS_W-1:0]  parent_q;
	logic                          neg_q;
	logic                          last_q;

	logic [pcs_pkg::UNIT_W-1:0]    rem_q;
	logic [pcs_pkg::SHIFT_W-1:0]   sh_q;
	logic [pcs_pkg::VSUM_W-1:0]    quo_q;
	logic [5:0]                    step_q;
	logic [pcs_pkg::VSUM_W:0]      q_q;
	logic [31:0]                   p_q;

	logic [pcs_pkg::SCORE_W-1:0]   lead_score_q;
	logic [pcs_pkg::ACTION_W-1:0]  best_action_q;
	logic [pcs_pkg::POS_W-1:0]     best_pos_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          first_q;

	logic                          m_tvalid_q;
	logic [pcs_pkg::M_TDATA_W-1:0] m_tdata_q;

	// Shared compare-subtract unit.
	logic [pcs_pkg::UNIT_W-1:0]    lhs, rhs;
	logic [pcs_pkg::UNIT_W:0]      diff;
	logic                          ge;
	logic [pcs_pkg::UNIT_W-1:0]    rem_next;
	logic [pcs_pkg::VSUM_W-1:0]    quo_next;

	logic                          accept;
	logic                          step_done;
	logic                          out_free;
	logic                          advance;
	logic [pcs_pkg::VSUM_W-1:0]    vsum_in;
	logic [pcs_pkg::VSUM_W-1:0]    mag_in;
	logic [pcs_pkg::VISITS_W:0]    dplus;
	logic [57:0]                   num;
	logic [pcs_pkg::VSUM_W+1:0]    total;
	logic [pcs_pkg::SCORE_W-1:0]   score;
	logic                          take;
	logic [pcs_pkg::SCORE_W-1:0]   win_score;
	logic [pcs_pkg::ACTION_W-1:0]  win_action;
	logic [pcs_pkg::POS_W-1:0]     win_pos;

	assign vsum_in  = s_tdata[85:49];
	assign mag_in   = vsum_in[pcs_pkg::VSUM_W-1] ? (~vsum_in + 1'b1) : vsum_in;
	assign dplus    = {1'b0, visits_q} + 1'b1;
	assign num      = 58'(p_q) * 58'(quo_q[pcs_pkg::ROOT_W-1:0]);
	assign step_done = (step_q == 6'd0);
	assign out_free = !m_tvalid_q || m_tready;
	assign advance  = !last_q || out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		case (state_q)
			pcs_pkg::ST_ROOT: begin
				lhs = {rem_q[pcs_pkg::UNIT_W-3:0], sh_q[pcs_pkg::SHIFT_W-1 -: 2]};
				rhs = {2'b00, quo_q[pcs_pkg::ROOT_W-1:0], 2'b01};
			end
			pcs_pkg::ST_UDIV: begin
				lhs = {rem_q[pcs_pkg::UNIT_W-2:0], sh_q[pcs_pkg::SHIFT_W-1]};
				rhs = pcs_pkg::UNIT_W'(dplus);
			end
			default: begin
				lhs = {rem_q[pcs_pkg::UNIT_W-2:0], sh_q[pcs_pkg::SHIFT_W-1]};
				rhs = pcs_pkg::UNIT_W'(visits_q);
			end
		endcase
		diff     = {1'b0, lhs} - {1'b0, rhs};
		ge       = !diff[pcs_pkg::UNIT_W];
		rem_next = ge ? diff[pcs_pkg::UNIT_W-1:0] : lhs;
		quo_next = {quo_q[pcs_pkg::VSUM_W-2:0], ge};
	end

	// Score of the current child and the running-best decision.
	always_comb begin
		total = {q_q[pcs_pkg::VSUM_W], q_q} +
			(pcs_pkg::VSUM_W+2)'(quo_q[pcs_pkg::UTERM_W-1:0]);
		if (!total[pcs_pkg::VSUM_W+1] && (total[pcs_pkg::VSUM_W:pcs_pkg::SCORE_W-1] != '0)) begin
			score = {1'b0, {(pcs_pkg::SCORE_W-1){1'b1}}};
		end else if (total[pcs_pkg::VSUM_W+1] &&
				(total[pcs_pkg::VSUM_W:pcs_pkg::SCORE_W-1] != '1)) begin
			score = {1'b1, {(pcs_pkg::SCORE_W-1){1'b0}}};
		end else begin
			score = total[pcs_pkg::SCORE_W-1:0];
		end
		take       = first_q || ($signed(score) > $signed(lead_score_q));
		win_score  = take ? score : lead_score_q;
		win_action = take ? action_q : best_action_q;
		win_pos    = take ? pcs_pkg::POS_W'(cnt_q) : best_pos_q;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			pcs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pcs_pkg::ST_QDIV;
				end
			end
			pcs_pkg::ST_QDIV: begin
				if (step_done) begin
					state_d = pcs_pkg::ST_ROOT;
				end
			end
			pcs_pkg::ST_ROOT: begin
				if (step_done) begin
					state_d = pcs_pkg::ST_MUL1;
				end
			end
			pcs_pkg::ST_MUL1: state_d = pcs_pkg::ST_MUL2;
			pcs_pkg::ST_MUL2: state_d = pcs_pkg::ST_UDIV;
			pcs_pkg::ST_UDIV: begin
				if (step_done) begin
					state_d = pcs_pkg::ST_SCORE;
				end
			end
			pcs_pkg::ST_SCORE: begin
				if (advance) begin
					state_d = pcs_pkg::ST_IDLE;
				end
			end
			default: state_d = pcs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= pcs_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// Operand capture and the iterative datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			pcs_pkg::ST_IDLE: begin
				if (accept) begin
					action_q <= s_tdata[12:0];
					prior_q  <= s_tdata[28:13];
					visits_q <= s_tdata[48:29];
					parent_q <= s_tdata[105:86];
					neg_q    <= vsum_in[pcs_pkg::VSUM_W-1];
					last_q   <= s_tlast;
					sh_q     <= {mag_in, {(pcs_pkg::SHIFT_W-pcs_pkg::VSUM_W){1'b0}}};
					rem_q    <= '0;
					quo_q    <= '0;
					step_q   <= 6'(pcs_pkg::VSUM_W - 1);
				end
			end
			pcs_pkg::ST_QDIV: begin
				if (step_done) begin
					// A child that was never visited has Q of zero.
					if (visits_q == '0) begin
						q_q <= '0;
					end else if (neg_q) begin
						q_q <= ~{1'b0, quo_next} + 1'b1;
					end else begin
						q_q <= {1'b0, quo_next};
					end
					sh_q   <= {parent_q, {(pcs_pkg::SHIFT_W-pcs_pkg::VISITS_W){1'b0}}};
					rem_q  <= '0;
					quo_q  <= '0;
					step_q <= 6'(pcs_pkg::ROOT_W - 1);
				end else begin
					sh_q   <= {sh_q[pcs_pkg::SHIFT_W-2:0], 1'b0};
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					step_q <= step_q - 1'b1;
				end
			end
			pcs_pkg::ST_ROOT: begin
				sh_q   <= {sh_q[pcs_pkg::SHIFT_W-3:0], 2'b00};
				rem_q  <= rem_next;
				quo_q  <= quo_next;
				step_q <= step_q - 1'b1;
			end
			pcs_pkg::ST_MUL1: begin
				p_q <= 32'(gain_q) * 32'(prior_q);
			end
			pcs_pkg::ST_MUL2: begin
				// Only the product bits at and above 2^28 go on to the exploration division.
				sh_q   <= {num[57:28], {(pcs_pkg::SHIFT_W-pcs_pkg::UTERM_W){1'b0}}};
				rem_q  <= '0;
				quo_q  <= '0;
				step_q <= 6'(pcs_pkg::UTERM_W - 1);
			end
			pcs_pkg::ST_UDIV: begin
				sh_q   <= {sh_q[pcs_pkg::SHIFT_W-2:0], 1'b0};
				rem_q  <= rem_next;
				quo_q  <= quo_next;
				step_q <= step_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Running best of the node and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_score_q  <= '0;
			best_action_q <= '0;
			best_pos_q    <= '0;
			cnt_q         <= '0;
			first_q       <= 1'b1;
			m_tvalid_q    <= 1'b0;
		end else begin
			if ((state_q == pcs_pkg::ST_SCORE) && advance && last_q) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if ((state_q == pcs_pkg::ST_SCORE) && advance) begin
				if (last_q) begin
					lead_score_q  <= '0;
					best_action_q <= '0;
					best_pos_q    <= '0;
					cnt_q         <= '0;
					first_q       <= 1'b1;
				end else begin
					lead_score_q  <= win_score;
					best_action_q <= win_action;
					best_pos_q    <= win_pos;
					cnt_q         <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
					first_q       <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == pcs_pkg::ST_SCORE) && advance && last_q) begin
			m_tdata_q <= {3'b000, win_score, win_pos, win_action};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
